@@ rtl/core/glu_pkg.sv @@
package glu_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int LCM_WIDTH   = 64;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_finish;
    logic div_step;
    logic mul;
  } cmd_t;

  typedef struct packed {
    logic any_zero;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

@@ rtl/core/glu_in_if.sv @@
interface glu_in_if
  import glu_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] first_value;
  logic [FIELD_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
endinterface

@@ rtl/core/glu_out_if.sv @@
interface glu_out_if
  import glu_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] gcd_value;
  logic [LCM_WIDTH-1:0]   lcm_value;
  logic                   both_zero;

  modport source (output valid, output gcd_value, output lcm_value, output both_zero,
                  input ready);
  modport sink (input valid, input gcd_value, input lcm_value, input both_zero,
                output ready);
endinterface

@@ rtl/core/glu_datapath.sv @@
module glu_datapath
  import glu_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cmd_t                   cmd,
  input  logic [FIELD_WIDTH-1:0] first_value,
  input  logic [FIELD_WIDTH-1:0] second_value,
  output status_t                status,
  output logic [FIELD_WIDTH-1:0] gcd_value,
  output logic [LCM_WIDTH-1:0]   lcm_value,
  output logic                   both_zero
);

  localparam int W  = VALUE_WIDTH;
  localparam int KW = $clog2(W + 1);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [KW-1:0]  k;
  logic [W-1:0]   g;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] prod;
  logic           zflag;

  logic [W-1:0]   x_in;
  logic [W-1:0]   y_in;
  logic [W:0]     trial;
  logic [W:0]     trial_diff;
  logic [W-1:0]   a_minus_b;
  logic [W-1:0]   b_minus_a;

  assign x_in       = first_value[W-1:0];
  assign y_in       = second_value[W-1:0];
  assign trial      = {rem, quo[W-1]};
  assign trial_diff = trial - {1'b0, g};
  assign a_minus_b  = a - b;
  assign b_minus_a  = b - a;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= x_in;
      y     <= y_in;
      a     <= x_in;
      b     <= y_in;
      k     <= '0;
      g     <= x_in | y_in;
      prod  <= '0;
      zflag <= (x_in == '0) && (y_in == '0);
    end
    if (cmd.gcd_step) begin
      // Stein's binary GCD: strip common factors of two, then subtract odd from odd.
      if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + KW'(1);
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a >= b) begin
        a <= a_minus_b >> 1;
      end else begin
        b <= b_minus_a >> 1;
      end
    end
    if (cmd.gcd_finish) begin
      g   <= (a | b) << k;
      rem <= '0;
      quo <= x;
      cnt <= CW'(W);
    end
    if (cmd.div_step) begin
      // Restoring division of x by the GCD, one quotient bit per cycle.
      if (!trial_diff[W]) begin
        rem <= trial_diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
    if (cmd.mul) begin
      prod <= (2*W)'(quo) * (2*W)'(y);
    end
  end

  assign status.any_zero = (x == '0) || (y == '0);
  assign status.gcd_done = (a == '0) || (b == '0);
  assign status.div_done = (cnt == '0);

  assign gcd_value = FIELD_WIDTH'(g);
  assign lcm_value = LCM_WIDTH'(prod);
  assign both_zero = zflag;

endmodule

@@ rtl/core/glu_ctrl.sv @@
module glu_ctrl
  import glu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    GCD,
    DIV,
    MUL,
    DONE
  } state_t;

  state_t state;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == DONE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == IDLE) && in_valid;
    cmd.gcd_step   = (state == GCD) && !status.gcd_done;
    cmd.gcd_finish = (state == GCD) && status.gcd_done;
    cmd.div_step   = (state == DIV) && !status.div_done;
    cmd.mul        = (state == MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= CHECK;
        end
        CHECK: begin
          // A zero operand already has its result set at load time.
          state <= status.any_zero ? DONE : GCD;
        end
        GCD: begin
          if (status.gcd_done) state <= DIV;
        end
        DIV: begin
          if (status.div_done) state <= MUL;
        end
        MUL: begin
          state <= DONE;
        end
        DONE: begin
          if (out_ready) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/gcd_lcm_unit.sv @@
// GCD and LCM of two unsigned operands, one item at a time.
// When an operand is zero the result is set at load and the GCD loop, divider
// and multiply are skipped; otherwise the item passes through the binary GCD
// loop, the bit-serial divider and the multiply. A new item is taken only once
// the last result is accepted. rst (synchronous, active high) returns the controller to idle.
module gcd_lcm_unit
  import glu_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  glu_in_if.sink   operands,
  glu_out_if.source results
);

  cmd_t    cmd;
  status_t status;

  glu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  glu_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .first_value  (operands.first_value),
    .second_value (operands.second_value),
    .status       (status),
    .gcd_value    (results.gcd_value),
    .lcm_value    (results.lcm_value),
    .both_zero    (results.both_zero)
  );

endmodule

@@ tb/tb_gcd_lcm_unit.sv @@
module tb_gcd_lcm_unit;
  import glu_pkg::*;

  localparam int VALUE_WIDTH  = 32;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 1730;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] gcd_value;
    logic [LCM_WIDTH-1:0]   lcm_value;
    logic                   both_zero;
  } glu_result_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] first_value;
    logic [FIELD_WIDTH-1:0] second_value;
    logic                   known;
    glu_result_t            result;
  } stim_row_t;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

  // Rows marked known carry the result typed in; the rest go through gcd_lcm_of.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 64'h0, 1'b1}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h0, 1'b0}},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0001, 64'h0, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h1, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 64'hFFFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'hFFFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 64'h8000_0000, 1'b0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h8000_0000, 1'b0}},
    '{32'hFFFF_FFFB, 32'hFFFF_FFEF, 1'b0, '0},
    '{32'h0000_000C, 32'h0000_0012, 1'b1, '{32'h0000_0006, 64'h24, 1'b0}},
    '{32'h0000_0012, 32'h0000_000C, 1'b1, '{32'h0000_0006, 64'h24, 1'b0}},
    '{32'h0000_0007, 32'h8000_0000, 1'b1, '{32'h0000_0001, 64'h3_8000_0000, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h5555_5555, 64'hAAAA_AAAA, 1'b0}},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h5555_5555, 64'hAAAA_AAAA, 1'b0}},
    '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
    // Consecutive Fibonacci numbers take the most Euclid rounds.
    '{32'hB119_24E1, 32'h6D73_E55F, 1'b0, '0}
  };

  logic clk;
  logic rst;

  glu_in_if  operands_if ();
  glu_out_if results_if ();

  gcd_lcm_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .operands(operands_if),
    .results (results_if)
  );

  glu_result_t pending_results[$];
  int unsigned accepted_count;
  int unsigned error_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic glu_result_t gcd_lcm_of(logic [FIELD_WIDTH-1:0] a,
                                             logic [FIELD_WIDTH-1:0] b);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] g;
    glu_result_t r;
    mask = (64'd1 << VALUE_WIDTH) - 64'd1;
    x = {32'd0, a} & mask;
    y = {32'd0, b} & mask;
    r = '0;
    if (x == 0 && y == 0) begin
      r.both_zero = 1'b1;
    end else if (x == 0 || y == 0) begin
      r.gcd_value = FIELD_WIDTH'(x | y);
    end else begin
      while (x != 0 && y != 0) begin
        if (x > y) begin
          x = x % y;
        end else begin
          y = y % x;
        end
      end
      g = (x == 0) ? y : x;
      r.gcd_value = FIELD_WIDTH'(g);
      r.lcm_value = ({32'd0, a} & mask) / g * ({32'd0, b} & mask);
    end
    return r;
  endfunction

  task automatic offer(input logic [FIELD_WIDTH-1:0] a, input logic [FIELD_WIDTH-1:0] b,
                       input glu_result_t expected);
    @(negedge clk);
    operands_if.valid        <= 1'b1;
    operands_if.first_value  <= a;
    operands_if.second_value <= b;
    do @(posedge clk); while (!operands_if.ready);
    pending_results.push_back(expected);
    accepted_count++;
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      operands_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic pick_operands(output logic [FIELD_WIDTH-1:0] a,
                               output logic [FIELD_WIDTH-1:0] b);
    int unsigned kind;
    int unsigned factor;
    kind = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    if (kind < 30) begin
      // Operands taken as they come.
    end else if (kind < 60) begin
      // A common factor of both operands makes the GCD nontrivial unless the factor is 1.
      factor = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF)
                                           : $urandom_range(1, 255);
      a = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
      b = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
    end else if (kind < 70) begin
      case ($urandom_range(0, 2))
        0: a = '0;
        1: b = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end else if (kind < 80) begin
      a = $urandom_range(1, 4096);
      b = a * $urandom_range(1, 32'hFFFF_FFFF / a);
      if ($urandom_range(0, 1)) begin
        {a, b} = {b, a};
      end
    end else if (kind < 90) begin
      a = $urandom_range(1, 1000);
      b = $urandom_range(1, 1000);
    end else begin
      a = 32'd1 << $urandom_range(0, 31);
      b = ($urandom_range(0, 1)) ? a : ($urandom << $urandom_range(0, 31));
    end
  endtask

  initial begin : stimulus
    logic [FIELD_WIDTH-1:0] a;
    logic [FIELD_WIDTH-1:0] b;
    int unsigned burst_left;
    rst = 1'b1;
    operands_if.valid        = 1'b0;
    operands_if.first_value  = '0;
    operands_if.second_value = '0;
    accepted_count = 0;
    error_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer(DIRECTED_ROWS[i].first_value, DIRECTED_ROWS[i].second_value,
            DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].result
                                   : gcd_lcm_of(DIRECTED_ROWS[i].first_value,
                                                DIRECTED_ROWS[i].second_value));
      pause($urandom_range(0, 2));
    end

    burst_left = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (burst_left == 0) begin
        pause(($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      pick_operands(a, b);
      offer(a, b, gcd_lcm_of(a, b));
    end
    pause(1);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("gcd_lcm_unit test passed");
    end else begin
      $display("gcd_lcm_unit test failed");
    end
    $finish;
  end

  // The receiver changes its stall pattern every so often, and once holds off
  // long enough for the block to back up onto its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    bit          held;
    ready_mode_t mode;
    results_if.ready = 1'b0;
    hold_left = 0;
    mode_left = 0;
    held      = 1'b0;
    mode      = READY_ALWAYS;
    forever begin
      @(negedge clk);
      if (!held && accepted_count >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: results_if.ready <= 1'b1;
          READY_RANDOM: results_if.ready <= 1'($urandom_range(0, 1));
          default:      results_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    glu_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with none expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (results_if.gcd_value !== want.gcd_value) begin
          $error("gcd_value: expected %0h, got %0h", want.gcd_value, results_if.gcd_value);
          error_count++;
        end
        if (results_if.lcm_value !== want.lcm_value) begin
          $error("lcm_value: expected %0h, got %0h", want.lcm_value, results_if.lcm_value);
          error_count++;
        end
        if (results_if.both_zero !== want.both_zero) begin
          $error("both_zero: expected %0b, got %0b", want.both_zero, results_if.both_zero);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #30_000_000;
    $display("gcd_lcm_unit test failed");
    $finish;
  end

endmodule

@@ gcd_lcm_unit.f @@
rtl/core/glu_pkg.sv
rtl/core/glu_in_if.sv
rtl/core/glu_out_if.sv
rtl/core/glu_datapath.sv
rtl/core/glu_ctrl.sv
rtl/core/gcd_lcm_unit.sv
tb/tb_gcd_lcm_unit.sv
